>>> design/rsdp_pkg.sv
// Shared widths, masks and item codes for the replicated-share dot product.
package rsdp_pkg;

  localparam int RING_BITS = 64;
  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;

  // Reduce to the ring: keep the low RING_BITS bits
  localparam word_t RING_MASK = {WORD_W{1'b1}} >> (WORD_W - RING_BITS);

  // Input item kinds
  localparam logic KIND_ELEM   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Result item kinds
  localparam logic RES_SEND   = 1'b0;
  localparam logic RES_SHARES = 1'b1;

endpackage

>>> design/rsdp_in_if.sv
// Input item channel: element and finish items with valid/ready handshake.
interface rsdp_in_if;
  logic            valid;
  logic            ready;
  logic            kind;
  rsdp_pkg::word_t share_a0;
  rsdp_pkg::word_t share_a1;
  rsdp_pkg::word_t share_b0;
  rsdp_pkg::word_t share_b1;
  logic            last;
  rsdp_pkg::word_t mask_next;
  rsdp_pkg::word_t mask_prev;
  rsdp_pkg::word_t peer_value;

  modport source (
    output valid, kind, share_a0, share_a1, share_b0, share_b1, last,
           mask_next, mask_prev, peer_value,
    input  ready
  );

  modport sink (
    input  valid, kind, share_a0, share_a1, share_b0, share_b1, last,
           mask_next, mask_prev, peer_value,
    output ready
  );
endinterface

>>> design/rsdp_out_if.sv
// Result item channel: masked send value or new share pair, valid/ready handshake.
interface rsdp_out_if;
  logic            valid;
  logic            ready;
  logic            result_kind;
  rsdp_pkg::word_t send_value;
  rsdp_pkg::word_t share_out0;
  rsdp_pkg::word_t share_out1;

  modport source (
    output valid, result_kind, send_value, share_out0, share_out1,
    input  ready
  );

  modport sink (
    input  valid, result_kind, send_value, share_out0, share_out1,
    output ready
  );
endinterface

>>> design/replicated_share_dot_product.sv
// Top level: replicated-share dot product with masked resharing.
// Path: an accepted item passes through the input register, the partial-product
//   register and the term register into the result register.
// Throughput: one item per cycle; the pipeline holds only while a result waits
//   on out_ch.ready, and the 64-bit products are split into 32x32 partial products.
// Reset: synchronous active-low rst_n clears the pipeline valids, the result valid,
//   the accumulator and the kept mask; no clearing pass is needed.
module replicated_share_dot_product (
  input  logic              clk,
  input  logic              rst_n,
  rsdp_in_if.sink           in_ch,
  rsdp_out_if.source        out_ch
);

  logic advance;

  // Input register
  logic            s0_valid_r;
  logic            s0_kind_r;
  logic            s0_last_r;
  rsdp_pkg::word_t s0_a0_r;
  rsdp_pkg::word_t s0_a1_r;
  rsdp_pkg::word_t s0_bs_r;
  rsdp_pkg::word_t s0_b0_r;
  rsdp_pkg::word_t s0_mnext_r;
  rsdp_pkg::word_t s0_mprev_r;
  rsdp_pkg::word_t s0_peer_r;

  // Partial-product register
  logic            s1_valid_r;
  logic            s1_kind_r;
  logic            s1_last_r;
  rsdp_pkg::word_t s1_mnext_r;
  rsdp_pkg::word_t s1_mprev_r;
  rsdp_pkg::word_t s1_peer_r;
  rsdp_pkg::word_t s1_pa_ll_r;
  rsdp_pkg::half_t s1_pa_x_r;
  rsdp_pkg::word_t s1_pb_ll_r;
  rsdp_pkg::half_t s1_pb_x_r;

  // Term register
  logic            s2_valid_r;
  logic            s2_kind_r;
  logic            s2_last_r;
  rsdp_pkg::word_t s2_mnext_r;
  rsdp_pkg::word_t s2_mprev_r;
  rsdp_pkg::word_t s2_peer_r;
  rsdp_pkg::word_t s2_term_r;

  // State and result register
  rsdp_pkg::word_t acc_r;
  rsdp_pkg::word_t acc_nxt;
  rsdp_pkg::word_t kept_r;
  rsdp_pkg::word_t kept_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_kind_r;
  logic            out_kind_nxt;
  rsdp_pkg::word_t out_send_r;
  rsdp_pkg::word_t out_send_nxt;
  rsdp_pkg::word_t out_sh0_r;
  rsdp_pkg::word_t out_sh0_nxt;
  rsdp_pkg::word_t out_sh1_r;
  rsdp_pkg::word_t out_sh1_nxt;

  // Partial products of a0*(b0+b1) and a1*b0, low 64 bits only
  rsdp_pkg::word_t pa_ll;
  rsdp_pkg::half_t pa_lh;
  rsdp_pkg::half_t pa_hl;
  rsdp_pkg::word_t pb_ll;
  rsdp_pkg::half_t pb_lh;
  rsdp_pkg::half_t pb_hl;
  rsdp_pkg::half_t cross_sum;
  rsdp_pkg::word_t acc_sum;

  // Hold the whole pipeline only while a result waits
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = advance;

  assign pa_ll = rsdp_pkg::word_t'(s0_a0_r[rsdp_pkg::HALF_W-1:0]) *
                 rsdp_pkg::word_t'(s0_bs_r[rsdp_pkg::HALF_W-1:0]);
  assign pa_lh = s0_a0_r[rsdp_pkg::HALF_W-1:0] * s0_bs_r[rsdp_pkg::WORD_W-1:rsdp_pkg::HALF_W];
  assign pa_hl = s0_a0_r[rsdp_pkg::WORD_W-1:rsdp_pkg::HALF_W] * s0_bs_r[rsdp_pkg::HALF_W-1:0];
  assign pb_ll = rsdp_pkg::word_t'(s0_a1_r[rsdp_pkg::HALF_W-1:0]) *
                 rsdp_pkg::word_t'(s0_b0_r[rsdp_pkg::HALF_W-1:0]);
  assign pb_lh = s0_a1_r[rsdp_pkg::HALF_W-1:0] * s0_b0_r[rsdp_pkg::WORD_W-1:rsdp_pkg::HALF_W];
  assign pb_hl = s0_a1_r[rsdp_pkg::WORD_W-1:rsdp_pkg::HALF_W] * s0_b0_r[rsdp_pkg::HALF_W-1:0];

  assign cross_sum = s1_pa_x_r + s1_pb_x_r;
  assign acc_sum   = acc_r + s2_term_r;

  always_comb begin
    acc_nxt       = acc_r;
    kept_nxt      = kept_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = rsdp_pkg::RES_SEND;
    out_send_nxt  = '0;
    out_sh0_nxt   = '0;
    out_sh1_nxt   = '0;
    if (s2_valid_r) begin
      if (s2_kind_r == rsdp_pkg::KIND_FINISH) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = rsdp_pkg::RES_SHARES;
        out_sh0_nxt   = (s2_mprev_r + acc_r) & rsdp_pkg::RING_MASK;
        out_sh1_nxt   = (s2_peer_r + kept_r) & rsdp_pkg::RING_MASK;
        acc_nxt       = '0;
      end else if (s2_last_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = rsdp_pkg::RES_SEND;
        out_send_nxt  = (acc_sum - s2_mnext_r) & rsdp_pkg::RING_MASK;
        acc_nxt       = out_send_nxt;
        kept_nxt      = s2_mnext_r & rsdp_pkg::RING_MASK;
      end else begin
        acc_nxt       = acc_sum & rsdp_pkg::RING_MASK;
      end
    end
  end

  // Control state and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      kept_r      <= '0;
    end else if (advance) begin
      s0_valid_r  <= in_ch.valid;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      kept_r      <= kept_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_kind_r  <= in_ch.kind;
      s0_last_r  <= in_ch.last;
      s0_a0_r    <= in_ch.share_a0;
      s0_a1_r    <= in_ch.share_a1;
      s0_bs_r    <= in_ch.share_b0 + in_ch.share_b1;
      s0_b0_r    <= in_ch.share_b0;
      s0_mnext_r <= in_ch.mask_next;
      s0_mprev_r <= in_ch.mask_prev;
      s0_peer_r  <= in_ch.peer_value;

      s1_kind_r  <= s0_kind_r;
      s1_last_r  <= s0_last_r;
      s1_mnext_r <= s0_mnext_r;
      s1_mprev_r <= s0_mprev_r;
      s1_peer_r  <= s0_peer_r;
      s1_pa_ll_r <= pa_ll;
      s1_pa_x_r  <= pa_lh + pa_hl;
      s1_pb_ll_r <= pb_ll;
      s1_pb_x_r  <= pb_lh + pb_hl;

      s2_kind_r  <= s1_kind_r;
      s2_last_r  <= s1_last_r;
      s2_mnext_r <= s1_mnext_r;
      s2_mprev_r <= s1_mprev_r;
      s2_peer_r  <= s1_peer_r;
      s2_term_r  <= s1_pa_ll_r + s1_pb_ll_r + {cross_sum, {rsdp_pkg::HALF_W{1'b0}}};

      out_kind_r <= out_kind_nxt;
      out_send_r <= out_send_nxt;
      out_sh0_r  <= out_sh0_nxt;
      out_sh1_r  <= out_sh1_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.send_value  = out_send_r;
  assign out_ch.share_out0  = out_sh0_r;
  assign out_ch.share_out1  = out_sh1_r;

endmodule
